>>> src/scrolling_column_marquee_unit_macros.svh
// --------------------------------------------------------------------------
// Scrolling column marquee assertion macros
// Shared property wrappers sampled on clk; the IMP and NXT forms are off while rst_n is low.
// --------------------------------------------------------------------------
`ifndef SCROLLING_COLUMN_MARQUEE_UNIT_MACROS_SVH
`define SCROLLING_COLUMN_MARQUEE_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define SCMQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scmq assertion failed");

// next-cycle implication, off during reset
`define SCMQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scmq assertion failed");

// next-cycle implication, also checked across reset
`define SCMQ_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("scmq reset assertion failed");

`endif

>>> src/scmq_pkg.sv
// --------------------------------------------------------------------------
// scmq_pkg
// Types and fixed constants of the scrolling column marquee.
// --------------------------------------------------------------------------
package scmq_pkg;

  localparam int ADDR_W     = 7;
  localparam int DATA_W     = 16;
  localparam int COL_IDX_W  = 5;
  localparam int IN_TDATA_W = 32;
  localparam int OUT_TDATA_W = 24;

  // input tdata field positions
  localparam int IN_ADDR_LSB  = 0;
  localparam int IN_DATA_LSB  = 7;
  localparam int IN_FAST_BIT  = 23;
  localparam int IN_RIGHT_BIT = 24;

  // prescaler
  localparam logic [3:0] PHASE_LAST = 4'd9;
  localparam logic [3:0] FAST_DIV   = 4'd5;

  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  data;
    logic               fast;
    logic               right;
  } cmd_t;

  typedef struct packed {
    logic vld;
    cmd_t cmd;
  } q_head_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } back_state_t;

endpackage

>>> src/scmq_front.sv
// --------------------------------------------------------------------------
// scmq_front
// Accepts input beats, drops out-of-range loads, queues commands (2 deep).
// --------------------------------------------------------------------------
module scmq_front #(
  parameter int MESSAGE_COLUMNS = 72
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [scmq_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [0:0]                  in_tuser,
  output scmq_pkg::q_head_t           q_head,
  input  logic                        q_pop
);
  import scmq_pkg::*;

  localparam int CMP_W = ADDR_W + 2;

  cmd_t       q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  cmd_t       cmd_in;
  logic       beat, keep, push, pop;

  always_comb begin
    cmd_in.kind  = cmd_kind_t'(in_tuser);
    cmd_in.addr  = in_tdata[IN_ADDR_LSB +: ADDR_W];
    cmd_in.data  = in_tdata[IN_DATA_LSB +: DATA_W];
    cmd_in.fast  = in_tdata[IN_FAST_BIT];
    cmd_in.right = in_tdata[IN_RIGHT_BIT];
  end

  assign in_tready = (count_r != 2'd2);
  assign beat      = in_tvalid && in_tready;
  // a load beyond the store has no effect, so it never enters the queue
  assign keep      = (cmd_in.kind == CMD_TICK) ||
                     ({2'b00, cmd_in.addr} < CMP_W'(MESSAGE_COLUMNS));
  assign push      = beat && keep;
  assign pop       = q_pop && (count_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  assign q_head.vld = (count_r != 2'd0);
  assign q_head.cmd = q_mem_r[rd_ptr_r];

endmodule

>>> src/scmq_back.sv
// --------------------------------------------------------------------------
// scmq_back
// Executes queued commands: column store writes and 24-column window scans,
// plus the scroll offset / prescaler update. Registered result stage.
// --------------------------------------------------------------------------
module scmq_back #(
  parameter int MESSAGE_COLUMNS = 72,
  parameter int WINDOW_COLUMNS  = 24,
  parameter int ROW_BITS        = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  scmq_pkg::q_head_t            q_head,
  output logic                         q_pop,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [scmq_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                         out_tlast
);
  import scmq_pkg::*;

  localparam int IDX_W = (MESSAGE_COLUMNS > 1) ? $clog2(MESSAGE_COLUMNS) : 1;
  localparam int OFS_W = $clog2(MESSAGE_COLUMNS + 2) + 1;
  localparam logic signed [OFS_W-1:0] M_S = OFS_W'(MESSAGE_COLUMNS);
  localparam logic signed [OFS_W-1:0] ONE_S = OFS_W'(1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MESSAGE_COLUMNS - 1);
  localparam logic [COL_IDX_W-1:0] WIN_LAST = COL_IDX_W'(WINDOW_COLUMNS - 1);
  localparam int PAD_W = OUT_TDATA_W - COL_IDX_W - DATA_W;

  logic [ROW_BITS-1:0] mem [MESSAGE_COLUMNS];

  back_state_t               state_r, state_nxt;
  logic [IDX_W-1:0]          ptr_r, ptr_nxt;
  logic [COL_IDX_W-1:0]      cnt_r, cnt_nxt;
  logic signed [OFS_W-1:0]   offset_r, offset_nxt;
  logic [3:0]                phase_r, phase_nxt;
  logic                      dir_r, dir_nxt;

  logic                      rd_vld_r, rd_vld_nxt;
  logic [COL_IDX_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                      rd_last_r, rd_last_nxt;
  logic [ROW_BITS-1:0]       mem_q_r;

  logic                      out_vld_r, out_vld_nxt;
  logic [COL_IDX_W-1:0]      out_idx_r;
  logic [ROW_BITS-1:0]       out_row_r;
  logic                      out_last_r;

  logic                      rd_en, mem_we, out_load, rd_free;
  logic signed [OFS_W-1:0]   base_s, offset_step;
  logic [3:0]                phase_step;
  logic                      do_step;

  assign out_load = rd_vld_r && (!out_vld_r || out_tready);
  assign rd_free  = !rd_vld_r || out_load;

  // window start, offset folded into 0..M-1
  always_comb begin
    if (offset_r < 0) begin
      base_s = offset_r + M_S;
    end else if (offset_r >= M_S) begin
      base_s = offset_r - M_S;
    end else begin
      base_s = offset_r;
    end
  end

  // prescaler and offset advance, using the direction stored before this tick
  always_comb begin
    if (dir_r) begin
      phase_step = (phase_r == PHASE_LAST) ? 4'd0 : phase_r + 4'd1;
    end else begin
      phase_step = (phase_r == 4'd0) ? PHASE_LAST : phase_r - 4'd1;
    end
    do_step = (phase_step == 4'd0) ||
              (q_head.cmd.fast && (phase_step == FAST_DIV));
    if (!do_step) begin
      offset_step = offset_r;
    end else if (dir_r) begin
      offset_step = offset_r + ONE_S;
    end else begin
      offset_step = offset_r - ONE_S;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ptr_nxt    = ptr_r;
    cnt_nxt    = cnt_r;
    offset_nxt = offset_r;
    phase_nxt  = phase_r;
    dir_nxt    = dir_r;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_head.vld) begin
          q_pop = 1'b1;
          if (q_head.cmd.kind == CMD_TICK) begin
            state_nxt = ST_SCAN;
            ptr_nxt   = IDX_W'(base_s);
            cnt_nxt   = '0;
            dir_nxt   = q_head.cmd.right;
            if ((offset_step > M_S) || (offset_step < -M_S)) begin
              offset_nxt = '0;
              phase_nxt  = 4'd0;
            end else begin
              offset_nxt = offset_step;
              phase_nxt  = phase_step;
            end
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (rd_free) begin
          rd_en   = 1'b1;
          ptr_nxt = (ptr_r == IDX_LAST) ? '0 : ptr_r + 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == WIN_LAST) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rd_idx_nxt  = rd_idx_r;
    rd_last_nxt = rd_last_r;
    if (rd_en) begin
      rd_vld_nxt  = 1'b1;
      rd_idx_nxt  = cnt_r;
      rd_last_nxt = (cnt_r == WIN_LAST);
    end else if (out_load) begin
      rd_vld_nxt = 1'b0;
    end else begin
      rd_vld_nxt = rd_vld_r;
    end
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      offset_r  <= '0;
      phase_r   <= 4'd0;
      dir_r     <= 1'b1;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      offset_r  <= offset_nxt;
      phase_r   <= phase_nxt;
      dir_r     <= dir_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    cnt_r     <= cnt_nxt;
    rd_idx_r  <= rd_idx_nxt;
    rd_last_r <= rd_last_nxt;
    if (out_load) begin
      out_idx_r  <= rd_idx_r;
      out_row_r  <= mem_q_r;
      out_last_r <= rd_last_r;
    end
  end

  // column store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[IDX_W'(q_head.cmd.addr)] <= ROW_BITS'(q_head.cmd.data);
    end
    if (rd_en) begin
      mem_q_r <= mem[ptr_r];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{PAD_W{1'b0}}, DATA_W'(out_row_r), out_idx_r};

endmodule

>>> src/scrolling_column_marquee_unit.sv
// A tick beat passes the queue, command step, store read and output register
// before its first column beat; 24 column beats follow, one per cycle while
// out_tready is high. A tick holds the scan engine for a command step plus
// one store read per column. Loads retire at one per cycle between scans.
// Synchronous active-low reset clears offset, prescaler, direction (to
// rightward) and all valids; the column store needs no clear and gets none.
// --------------------------------------------------------------------------
// scrolling_column_marquee_unit
// LED column marquee: column store loads and scrolling window scans.
// --------------------------------------------------------------------------
module scrolling_column_marquee_unit #(
  parameter int MESSAGE_COLUMNS = 72,
  parameter int WINDOW_COLUMNS  = 24,
  parameter int ROW_BITS        = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [6:0] column_address, [22:7] column_data, [23] speed_fast,
  // [24] direction_right, [31:25] zero
  input  logic [scmq_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] action
  input  logic [0:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [4:0] column_index, [20:5] row_bits, [23:21] zero
  output logic [scmq_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tlast
);
  import scmq_pkg::*;

  q_head_t q_head;
  logic    q_pop;

  scmq_front #(
    .MESSAGE_COLUMNS (MESSAGE_COLUMNS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  scmq_back #(
    .MESSAGE_COLUMNS (MESSAGE_COLUMNS),
    .WINDOW_COLUMNS  (WINDOW_COLUMNS),
    .ROW_BITS        (ROW_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> src/scmq_checker.sv
// --------------------------------------------------------------------------
// scmq_checker
// Port-level checks of the marquee result stream and of reset, bound to the top level.
// --------------------------------------------------------------------------
`include "scrolling_column_marquee_unit_macros.svh"

module scmq_checker #(
  parameter int WINDOW_COLUMNS = 24
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [scmq_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                              out_tlast
);
  import scmq_pkg::*;

  localparam logic [COL_IDX_W-1:0] WIN_LAST = COL_IDX_W'(WINDOW_COLUMNS - 1);

  logic [COL_IDX_W-1:0] exp_idx_r;
  logic                 out_beat;

  assign out_beat = out_tvalid && out_tready;

  // column index expected on the next result beat of the scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
    end else if (out_beat) begin
      exp_idx_r <= out_tlast ? '0 : exp_idx_r + 1'b1;
    end
  end

  `SCMQ_ASSERT_RST(a_reset_no_out, !rst_n, !out_tvalid)
  `SCMQ_ASSERT_RST(a_reset_ready, !rst_n, in_tready)
  `SCMQ_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `SCMQ_ASSERT_IMP(a_idx_seq, out_beat, out_tdata[COL_IDX_W-1:0] == exp_idx_r)
  `SCMQ_ASSERT_IMP(a_last_pos, out_beat, out_tlast == (out_tdata[COL_IDX_W-1:0] == WIN_LAST))

endmodule

bind scrolling_column_marquee_unit scmq_checker #(
  .WINDOW_COLUMNS (WINDOW_COLUMNS)
) u_scmq_checker (.*);
